>>> rtl/core/gvn_pkg.sv
// shared types and constants for the grid vertex normal unit
package gvn_pkg;
  localparam int CoordW = 24;
  localparam int NormW = 16;
  localparam int SumW = 56;
  localparam int MagW = 32;
  localparam int CfgW = 9;
  localparam logic [0:0] OpWrite = 1'b0;
  localparam logic [0:0] OpQuery = 1'b1;
  localparam logic [0:0] RegColumns = 1'b0;
  localparam logic [0:0] RegRows = 1'b1;

  typedef struct packed {
    logic [0:0] operation;
    logic [7:0] col;
    logic [7:0] row;
    logic signed [CoordW-1:0] pos_x;
    logic signed [CoordW-1:0] pos_y;
    logic signed [CoordW-1:0] pos_z;
  } in_item_t;

  typedef struct packed {
    logic signed [NormW-1:0] normal_x;
    logic signed [NormW-1:0] normal_y;
    logic signed [NormW-1:0] normal_z;
    logic degenerate;
  } out_item_t;

  typedef struct packed {
    logic [0:0] index;
    logic [CfgW-1:0] data;
  } cfg_item_t;

  typedef struct packed {
    logic start;
    logic zero;
    logic [2:0] neg;
    logic [MagW-1:0] mag_x;
    logic [MagW-1:0] mag_y;
    logic [MagW-1:0] mag_z;
  } norm_req_t;
endpackage

>>> rtl/core/gvn_if.sv
// valid/ready channel interfaces
interface gvn_in_if;
  import gvn_pkg::*;
  logic valid;
  logic ready;
  in_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gvn_out_if;
  import gvn_pkg::*;
  logic valid;
  logic ready;
  out_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

interface gvn_cfg_if;
  import gvn_pkg::*;
  logic valid;
  logic ready;
  cfg_item_t data;
  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/gvn_store.sv
// vertex position memory, one read or write port
module gvn_store #(
  parameter int Depth = 65536
) (
  input  logic clk_i,
  input  logic we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [3*gvn_pkg::CoordW-1:0] wdata_i,
  output logic [3*gvn_pkg::CoordW-1:0] rdata_o
);
  import gvn_pkg::*;
  logic [3*CoordW-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem[addr_i] <= wdata_i;
    rdata_o <= mem[addr_i];
  end
endmodule

>>> rtl/core/gvn_norm.sv
// normalization: square sum, integer square root and divisions
module gvn_norm (
  input  logic clk_i,
  input  logic rst_ni,
  input  gvn_pkg::norm_req_t req_i,
  output logic busy_o,
  output logic done_o,
  output gvn_pkg::out_item_t res_o
);
  import gvn_pkg::*;
  localparam logic [2:0] SIdle = 3'd0, SSq = 3'd1, SSqrt = 3'd2, SDiv = 3'd3, SDone = 3'd4;
  logic [2:0] st_q;
  logic [MagW-1:0] m_q [3];
  logic [2:0] neg_q;
  logic [1:0] cnt_q;
  logic [65:0] sq_q, rem_q;
  logic [32:0] root_q;
  logic [5:0] it_q;
  logic [48:0] num_q, drem_q;
  logic [33:0] den_q;
  logic [15:0] quo_q;
  logic [NormW-1:0] n_q [3];
  logic [MagW-1:0] m2;
  logic [63:0] prod;
  logic [65:0] trial;
  logic [49:0] dsh;

  assign m2 = m_q[cnt_q];
  assign prod = 64'(m2) * 64'(m2);
  assign trial = {rem_q[63:0], sq_q[65:64]} - {30'd0, root_q, 2'b01};
  assign dsh = {drem_q, num_q[48]};
  assign busy_o = st_q != SIdle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      unique case (st_q)
        SIdle: if (req_i.start) begin
          neg_q <= req_i.neg;
          m_q[0] <= req_i.mag_x; m_q[1] <= req_i.mag_y; m_q[2] <= req_i.mag_z;
          cnt_q <= 2'd0; sq_q <= '0;
          if (req_i.zero) begin
            res_o <= '{normal_x: '0, normal_y: '0, normal_z: '0, degenerate: 1'b1};
            done_o <= 1'b1;
          end else st_q <= SSq;
        end
        SSq: begin
          sq_q <= sq_q + 66'(prod);
          if (cnt_q == 2'd2) begin
            st_q <= SSqrt; rem_q <= '0; root_q <= '0; it_q <= '0;
          end else cnt_q <= cnt_q + 2'd1;
        end
        SSqrt: begin
          sq_q <= {sq_q[63:0], 2'b00};
          if (!trial[65]) begin
            rem_q <= trial; root_q <= {root_q[31:0], 1'b1};
          end else begin
            rem_q <= {rem_q[63:0], sq_q[65:64]}; root_q <= {root_q[31:0], 1'b0};
          end
          if (it_q == 6'd32) begin
            st_q <= SDiv; cnt_q <= 2'd0; it_q <= '0;
          end else it_q <= it_q + 6'd1;
        end
        SDiv: begin
          if (it_q == 6'd0) begin
            num_q <= 49'({m_q[cnt_q], 15'd0}) + 49'(root_q);
            den_q <= {root_q, 1'b0};
            drem_q <= '0; quo_q <= '0; it_q <= 6'd1;
          end else begin
            num_q <= {num_q[47:0], 1'b0};
            if (dsh >= 50'(den_q)) begin
              drem_q <= 49'(dsh - 50'(den_q)); quo_q <= {quo_q[14:0], 1'b1};
            end else begin
              drem_q <= dsh[48:0]; quo_q <= {quo_q[14:0], 1'b0};
            end
            if (it_q == 6'd49) begin
              it_q <= '0;
              if (cnt_q == 2'd2) st_q <= SDone; else cnt_q <= cnt_q + 2'd1;
            end else it_q <= it_q + 6'd1;
          end
          if (it_q == 6'd49) begin
            n_q[cnt_q] <= neg_q[cnt_q]
                ? -$signed({quo_q[14:0], dsh >= 50'(den_q)})
                : $signed({quo_q[14:0], dsh >= 50'(den_q)});
          end
        end
        SDone: begin
          res_o <= '{normal_x: n_q[0], normal_y: n_q[1], normal_z: n_q[2],
                     degenerate: 1'b0};
          done_o <= 1'b1; st_q <= SIdle;
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

>>> rtl/core/gvn_ctrl.sv
// query sequencer: neighbour reads, cross products, sum, scaling
module gvn_ctrl #(
  parameter int MaxColumns = 256,
  parameter int MaxRows = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  gvn_in_if.sink in_ch,
  gvn_cfg_if.sink cfg_ch,
  input  logic norm_busy_i,
  input  logic out_full_i,
  output logic we_o,
  output logic [$clog2(MaxColumns)+$clog2(MaxRows)-1:0] addr_o,
  output logic [3*gvn_pkg::CoordW-1:0] wdata_o,
  input  logic [3*gvn_pkg::CoordW-1:0] rdata_i,
  output gvn_pkg::norm_req_t req_o
);
  import gvn_pkg::*;
  localparam int CW = $clog2(MaxColumns);
  localparam int AW = CW + $clog2(MaxRows);
  localparam logic [3:0] SIdle = 4'd0, SRead = 4'd1, SWait = 4'd2, SCross = 4'd3,
                         SAbs = 4'd4, SUp = 4'd5, SDn = 4'd6, SGo = 4'd7;
  localparam int EW = CoordW + 1;

  logic [CfgW-1:0] cols_q, rows_q, cols, rows;
  logic [3:0] st_q;
  logic [7:0] c_q, r_q;
  logic [2:0] rd_q;
  logic [1:0] k_q;
  logic [1:0] ph_q;
  logic signed [CoordW-1:0] v_q [5][3];
  logic [3:0] has_q;
  logic signed [SumW-1:0] s_q [3];
  logic signed [EW-1:0] ea [3], eb [3];
  logic signed [2*EW-1:0] p_q;
  logic [SumW-1:0] mg_q [3];
  logic [2:0] ng_q;
  logic [SumW-1:0] mx;
  logic [1:0] nb_a, nb_b;
  logic [7:0] rc, rr;
  logic hu, hr, hd, hl, in_grid, have;

  assign cols = (cols_q < 9'd2) ? 9'd2 : (int'(cols_q) > MaxColumns) ? 9'(MaxColumns) : cols_q;
  assign rows = (rows_q < 9'd2) ? 9'd2 : (int'(rows_q) > MaxRows) ? 9'(MaxRows) : rows_q;
  assign in_grid = 9'(in_ch.data.col) < cols && 9'(in_ch.data.row) < rows;
  assign hu = 9'(in_ch.data.row) + 9'd1 < rows;
  assign hr = 9'(in_ch.data.col) + 9'd1 < cols;
  assign hd = in_ch.data.row != 8'd0;
  assign hl = in_ch.data.col != 8'd0;
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready = st_q == SIdle && !norm_busy_i && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= 9'd256; rows_q <= 9'd256;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.data.index == RegColumns) cols_q <= cfg_ch.data.data;
      else rows_q <= cfg_ch.data.data;
    end
  end

  // neighbour order: 0 center, 1 up, 2 right, 3 down, 4 left
  always_comb begin
    rc = c_q; rr = r_q;
    case (rd_q)
      3'd1: rr = r_q + 8'd1;
      3'd2: rc = c_q + 8'd1;
      3'd3: rr = r_q - 8'd1;
      3'd4: rc = c_q - 8'd1;
      default: ;
    endcase
  end

  always_comb begin
    we_o = 1'b0;
    addr_o = AW'({rr, CW'(rc)});
    wdata_o = {in_ch.data.pos_x, in_ch.data.pos_y, in_ch.data.pos_z};
    if (st_q == SIdle) begin
      addr_o = AW'({in_ch.data.row, CW'(in_ch.data.col)});
      we_o = in_ch.valid && in_ch.ready && in_ch.data.operation == OpWrite && in_grid;
    end
  end

  // corner k uses edges (a,b): (right,up) (down,right) (left,down) (up,left)
  always_comb begin
    case (k_q)
      2'd0: begin nb_a = 2'd1; nb_b = 2'd0; end
      2'd1: begin nb_a = 2'd2; nb_b = 2'd1; end
      2'd2: begin nb_a = 2'd3; nb_b = 2'd2; end
      default: begin nb_a = 2'd0; nb_b = 2'd3; end
    endcase
    have = has_q[nb_a] && has_q[nb_b];
    for (int i = 0; i < 3; i++) begin
      ea[i] = EW'(v_q[3'(nb_a)+3'd1][i]) - EW'(v_q[0][i]);
      eb[i] = EW'(v_q[3'(nb_b)+3'd1][i]) - EW'(v_q[0][i]);
    end
    mx = mg_q[0];
    if (mg_q[1] > mx) mx = mg_q[1];
    if (mg_q[2] > mx) mx = mg_q[2];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle;
      req_o.start <= 1'b0;
    end else begin
      req_o.start <= 1'b0;
      unique case (st_q)
        SIdle: if (in_ch.valid && in_ch.ready && in_ch.data.operation == OpQuery) begin
          c_q <= in_ch.data.col; r_q <= in_ch.data.row;
          has_q <= {hl, hd, hr, hu};
          for (int i = 0; i < 3; i++) s_q[i] <= '0;
          if (!in_grid) begin
            req_o.zero <= 1'b1; req_o.start <= 1'b1;
          end else begin
            rd_q <= 3'd0; st_q <= SRead;
          end
        end
        SRead: st_q <= SWait;
        SWait: begin
          v_q[rd_q][0] <= rdata_i[3*CoordW-1:2*CoordW];
          v_q[rd_q][1] <= rdata_i[2*CoordW-1:CoordW];
          v_q[rd_q][2] <= rdata_i[CoordW-1:0];
          if (rd_q == 3'd4) begin
            st_q <= SCross; k_q <= 2'd0; ph_q <= 2'd0;
          end else begin
            rd_q <= rd_q + 3'd1; st_q <= SRead;
          end
        end
        SCross: begin
          // ph 0..2 products for component ph, one held in p_q and the other formed in SGo
          if (!have) begin
            s_q[2] <= s_q[2] + SumW'(65536);
            k_q <= k_q + 2'd1;
            if (k_q == 2'd3) st_q <= SAbs;
          end else begin
            case (ph_q)
              2'd0: p_q <= ea[1] * eb[2];
              2'd1: p_q <= ea[2] * eb[0];
              default: p_q <= ea[0] * eb[1];
            endcase
            st_q <= SGo;
          end
        end
        SGo: begin
          case (ph_q)
            2'd0: s_q[0] <= s_q[0] + SumW'(p_q) - SumW'(ea[2] * eb[1]);
            2'd1: s_q[1] <= s_q[1] + SumW'(p_q) - SumW'(ea[0] * eb[2]);
            default: s_q[2] <= s_q[2] + SumW'(p_q) - SumW'(ea[1] * eb[0]);
          endcase
          st_q <= SCross;
          if (ph_q == 2'd2) begin
            ph_q <= 2'd0; k_q <= k_q + 2'd1;
            if (k_q == 2'd3) st_q <= SAbs;
          end else ph_q <= ph_q + 2'd1;
        end
        SAbs: begin
          for (int i = 0; i < 3; i++) begin
            ng_q[i] <= s_q[i][SumW-1];
            mg_q[i] <= s_q[i][SumW-1] ? SumW'(-s_q[i]) : SumW'(s_q[i]);
          end
          st_q <= SUp;
        end
        SUp: begin
          if (mx == '0) begin
            req_o.zero <= 1'b1; req_o.start <= 1'b1; st_q <= SIdle;
          end else if (mx >= (SumW'(1) << 31)) begin
            for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] >> 1;
          end else st_q <= SDn;
        end
        SDn: begin
          if (mx < (SumW'(1) << 30)) begin
            for (int i = 0; i < 3; i++) mg_q[i] <= mg_q[i] << 1;
          end else begin
            req_o.zero <= 1'b0; req_o.neg <= ng_q;
            req_o.mag_x <= MagW'(mg_q[0]); req_o.mag_y <= MagW'(mg_q[1]);
            req_o.mag_z <= MagW'(mg_q[2]);
            req_o.start <= 1'b1; st_q <= SIdle;
          end
        end
        default: st_q <= SIdle;
      endcase
    end
  end
endmodule

>>> rtl/core/grid_vertex_normal_unit.sv
// top level of the grid vertex normal unit
// Stores vertex positions row-major in a single-port memory and, per query, returns the
// unit normal of the four surrounding corner cross products. A query runs the five
// memory reads, the cross products on a pair of multipliers, the scaling shifts, the
// square sum, 33 square-root steps and three restoring divisions. A query outside
// the grid or with a zero sum answers with a degenerate zero normal. The result
// waits in an output register; the next item is taken once it is free.
module grid_vertex_normal_unit #(
  parameter int MaxColumns = 256,
  parameter int MaxRows = 256
) (
  input  logic clk_i,
  input  logic rst_ni,
  gvn_in_if.sink in_ch,
  gvn_cfg_if.sink cfg_ch,
  gvn_out_if.source out_ch
);
  import gvn_pkg::*;
  localparam int Depth = (2 ** $clog2(MaxColumns)) * MaxRows;
  logic we;
  logic [$clog2(Depth)-1:0] addr;
  logic [3*CoordW-1:0] wdata, rdata;
  norm_req_t req;
  logic busy, done, full_q;
  out_item_t res;

  gvn_store #(.Depth(Depth)) u_store (
    .clk_i, .we_i(we), .addr_i(addr), .wdata_i(wdata), .rdata_o(rdata)
  );
  gvn_ctrl #(.MaxColumns(MaxColumns), .MaxRows(MaxRows)) u_ctrl (
    .clk_i, .rst_ni, .in_ch, .cfg_ch, .norm_busy_i(busy || req.start || done),
    .out_full_i(full_q), .we_o(we), .addr_o(addr), .wdata_o(wdata), .rdata_i(rdata),
    .req_o(req)
  );
  gvn_norm u_norm (
    .clk_i, .rst_ni, .req_i(req), .busy_o(busy), .done_o(done), .res_o(res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) full_q <= 1'b0;
    else if (done) full_q <= 1'b1;
    else if (out_ch.ready) full_q <= 1'b0;
  end
  assign out_ch.valid = full_q;
  assign out_ch.data = res;
endmodule
